// ===== rtl/rhtt_pkg.sv =====
// Package for the rectangle hit-test table: request, response and entry word types,
// command and status codes.
// No dependencies.
package rhtt_pkg;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_FIND   = 2'd2;
   localparam logic [1:0] CMD_READ   = 2'd3;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_FULL  = 2'd1;
   localparam logic [1:0] STS_RANGE = 2'd2;
   localparam logic [1:0] STS_MISS  = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [14:0]        size_x;
      logic [14:0]        size_y;
      logic [7:0]         index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         hit_index;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [14:0]        width;
      logic [14:0]        height;
   } entry_type;

endpackage

// ===== rtl/rhtt_hit_cmp.sv =====
// Containment test of one point against one stored rectangle (half-open area).
// Depends on rhtt_pkg.
module rhtt_hit_cmp (
   input  logic signed [15:0] point_x,
   input  logic signed [15:0] point_y,
   input  rhtt_pkg::entry_type entry,
   output logic               hit
);
   import rhtt_pkg::*;

   logic signed [16:0] px_ext;
   logic signed [16:0] py_ext;
   logic signed [16:0] ox_ext;
   logic signed [16:0] oy_ext;
   logic signed [16:0] x_end;
   logic signed [16:0] y_end;

   assign px_ext = {point_x[15], point_x};
   assign py_ext = {point_y[15], point_y};
   assign ox_ext = {entry.origin_x[15], entry.origin_x};
   assign oy_ext = {entry.origin_y[15], entry.origin_y};
   // 17 bits hold origin plus size without wrap
   assign x_end  = ox_ext + signed'({2'b00, entry.width});
   assign y_end  = oy_ext + signed'({2'b00, entry.height});

   assign hit = (px_ext >= ox_ext) && (py_ext >= oy_ext) &&
                (px_ext < x_end) && (py_ext < y_end);

endmodule

// ===== rtl/rectangle_hit_test_table_unit.sv =====
// Rectangle hit-test table: entry memory, command sequencer and response register.
// Depends on rhtt_pkg and rhtt_hit_cmp.
//
// Usage:
//   req_valid/req_stall/req_word carry one command word; rsp_valid/rsp_stall/
//   rsp_word return exactly one response word per command, in order.
//   A word moves when valid is high and stall is low at a rising clock edge.
//   One command is worked on at a time; req_stall is high from acceptance
//   until its response is loaded into the output register.
//   Work per command, from acceptance to rsp_valid (entry memory has one
//   write and one registered read port, one entry touched per cycle):
//     append, or any command rejected by a range/full check: straight to the response
//     read origin: registered entry read, then the response
//     remove at index i: each later entry moves down one place, none when i is the last entry
//     find: scan newest to oldest, stops on first hit
//   The next command is accepted the cycle after a response is loaded,
//   even while the receiver still stalls it.
//   A stalled response holds; a finished command waits for the output slot.
//   Synchronous reset empties the table and drops any pending response;
//   entry contents are not cleared.
module rectangle_hit_test_table_unit #(
   parameter int CAPACITY = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rhtt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rhtt_pkg::rsp_word_type rsp_word
);
   import rhtt_pkg::*;

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_SCAN  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic         pend_ff, pend_in;
   logic         issue_ff, issue_in;
   req_word_type req_ff, req_in;
   rsp_word_type res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   entry_type    mem [CAPACITY];
   entry_type    rd_data_ff;
   logic         rd_en;
   logic [AW-1:0] rd_addr;
   logic         wr_en;
   logic [AW-1:0] wr_addr;
   entry_type    wr_data;

   logic [CMPW-1:0] idx_wide;
   logic [CMPW-1:0] cnt_wide;
   logic [CMPW-1:0] hit_wide;
   logic [CW:0]     ptr_next;
   logic            hit;

   rhtt_hit_cmp u_hit_cmp (
      .point_x (req_ff.point_x),
      .point_y (req_ff.point_y),
      .entry   (rd_data_ff),
      .hit     (hit)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign idx_wide = CMPW'(req_word.index);
   assign cnt_wide = CMPW'(count_ff);
   assign hit_wide = CMPW'(wr_addr_ff);
   assign ptr_next = {1'b0, ptr_ff} + (CW + 1)'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      wr_addr_in   = wr_addr_ff;
      pend_in      = 1'b0;
      issue_in     = issue_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_word;
               res_in = '0;
               unique case (req_word.command)
                  CMD_APPEND: begin
                     state_in = S_RESP;
                     if (count_ff == CW'(CAPACITY)) begin
                        res_in.status = STS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = count_ff[AW-1:0];
                        wr_data.origin_x = req_word.point_x;
                        wr_data.origin_y = req_word.point_y;
                        wr_data.width    = req_word.size_x;
                        wr_data.height   = req_word.size_y;
                        count_in = count_ff + CW'(1);
                        res_in.status = STS_OK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (idx_wide >= cnt_wide) begin
                        res_in.status = STS_RANGE;
                        state_in = S_RESP;
                     end else begin
                        ptr_in   = idx_wide[CW-1:0];
                        state_in = S_SHIFT;
                     end
                  end
                  CMD_FIND: begin
                     if (count_ff == '0) begin
                        res_in.status = STS_MISS;
                        state_in = S_RESP;
                     end else begin
                        ptr_in   = count_ff - CW'(1);
                        issue_in = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  CMD_READ: begin
                     if (idx_wide >= cnt_wide) begin
                        res_in.status = STS_RANGE;
                        state_in = S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_wide[AW-1:0];
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_READ: begin
            res_in.status   = STS_OK;
            res_in.origin_x = rd_data_ff.origin_x;
            res_in.origin_y = rd_data_ff.origin_y;
            state_in = S_RESP;
         end
         S_SHIFT: begin
            // read entry ptr+1, write it to ptr in the next cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_addr_ff;
               wr_data = rd_data_ff;
            end
            if (ptr_next < {1'b0, count_ff}) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_next[AW-1:0];
               wr_addr_in = ptr_ff[AW-1:0];
               pend_in    = 1'b1;
               ptr_in     = ptr_next[CW-1:0];
            end else if (!pend_ff) begin
               count_in      = count_ff - CW'(1);
               res_in.status = STS_OK;
               state_in      = S_RESP;
            end
         end
         S_SCAN: begin
            if (pend_ff && hit) begin
               res_in.status    = STS_OK;
               res_in.hit_index = hit_wide[7:0];
               state_in = S_RESP;
            end else if (pend_ff && (wr_addr_ff == '0)) begin
               res_in.status = STS_MISS;
               state_in = S_RESP;
            end else if (issue_ff) begin
               rd_en      = 1'b1;
               rd_addr    = ptr_ff[AW-1:0];
               wr_addr_in = ptr_ff[AW-1:0];
               pend_in    = 1'b1;
               if (ptr_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - CW'(1);
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               issue_in     = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      wr_addr_ff  <= wr_addr_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== tb/rectangle_hit_test_table_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench for rectangle_hit_test_table_unit: directed and random command words,
// each response checked against an in-bench model of the rectangle table.
// Depends on rhtt_pkg and rectangle_hit_test_table_unit.
module rectangle_hit_test_table_unit_test;
   import rhtt_pkg::*;

   localparam int CAPACITY    = 256;
   localparam int QUIET_TAIL  = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int RECENT      = 64;

   typedef enum {MIX_GROW, MIX_CHURN, MIX_SHRINK} mix_kind_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   req_word_type command_words[$];
   rsp_word_type expected_rsp_words[$];

   entry_type table_entries[CAPACITY];
   int        table_count   = 0;
   int        word_total    = 0;
   int        sent_count    = 0;
   int        checked_count = 0;
   int        error_count   = 0;
   int        send_gap      = 0;
   int        stall_left    = 0;
   int        hold_left     = 0;
   bit        hold_done     = 1'b0;

   // stimulus-side tracking of table fill, and recent rectangles to aim finds at
   int        planned_count = 0;
   entry_type recent_rects[RECENT];
   int        recent_total  = 0;

   rectangle_hit_test_table_unit #(.CAPACITY(CAPACITY)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit idle_allowed(input int n);
      return (n < word_total - QUIET_TAIL) && ((n / 150) % 4 != 3);
   endfunction

   function automatic rsp_word_type run_table_command(input req_word_type w);
      rsp_word_type r;
      int px, py, ox, oy, i, idx;
      bit found;
      r = '0;
      px = $signed(w.point_x);
      py = $signed(w.point_y);
      idx = int'(w.index);
      case (w.command)
         CMD_APPEND: begin
            if (table_count >= CAPACITY) begin
               r.status = STS_FULL;
            end else begin
               table_entries[table_count] = '{origin_x: w.point_x, origin_y: w.point_y,
                                              width: w.size_x, height: w.size_y};
               table_count++;
            end
         end
         CMD_REMOVE: begin
            if (idx >= table_count) begin
               r.status = STS_RANGE;
            end else begin
               for (i = idx; i + 1 < table_count; i++)
                  table_entries[i] = table_entries[i + 1];
               table_count--;
            end
         end
         CMD_FIND: begin
            found = 1'b0;
            r.status = STS_MISS;
            for (i = table_count - 1; i >= 0 && !found; i--) begin
               ox = $signed(table_entries[i].origin_x);
               oy = $signed(table_entries[i].origin_y);
               if (px >= ox && py >= oy && px < ox + int'(table_entries[i].width) &&
                   py < oy + int'(table_entries[i].height)) begin
                  found = 1'b1;
                  r.status = STS_OK;
                  r.hit_index = i[7:0];
               end
            end
         end
         default: begin
            if (idx >= table_count) begin
               r.status = STS_RANGE;
            end else begin
               r.origin_x = table_entries[idx].origin_x;
               r.origin_y = table_entries[idx].origin_y;
            end
         end
      endcase
      return r;
   endfunction

   task automatic add_word(input logic [1:0] cmd, input int px, input int py,
                           input int sx, input int sy, input int idx);
      req_word_type w;
      w.command = cmd;
      w.point_x = px[15:0];
      w.point_y = py[15:0];
      w.size_x  = sx[14:0];
      w.size_y  = sy[14:0];
      w.index   = idx[7:0];
      command_words.push_back(w);
      if (cmd == CMD_APPEND && planned_count < CAPACITY) begin
         planned_count++;
         recent_rects[recent_total % RECENT] = '{origin_x: w.point_x, origin_y: w.point_y,
                                                 width: w.size_x, height: w.size_y};
         recent_total++;
      end
      if (cmd == CMD_REMOVE && int'(w.index) < planned_count)
         planned_count--;
   endtask

   function automatic int rand_coord();
      if ($urandom_range(0, 1))
         return int'($urandom_range(0, 127)) - 64;
      return $urandom();
   endfunction

   function automatic int rand_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      if (r < 3)
         return $urandom_range(0, 32767);
      if (r < 6)
         return $urandom_range(1, 48);
      return $urandom_range(1, 600);
   endfunction

   function automatic int pick_index();
      int r, n;
      r = $urandom_range(0, 9);
      if (planned_count == 0 || r == 0)
         return $urandom_range(0, 255);
      if (r == 1) begin
         n = planned_count + $urandom_range(0, 2);
         return (n > 255) ? 255 : n;
      end
      return $urandom_range(0, planned_count - 1);
   endfunction

   task automatic add_random_word(input mix_kind_type mix);
      int r, lim_append, lim_remove, lim_find, px, py, n;
      logic [1:0] cmd;
      entry_type e;
      case (mix)
         MIX_GROW:  begin lim_append = 80; lim_remove = 85; lim_find = 95; end
         MIX_CHURN: begin lim_append = 30; lim_remove = 50; lim_find = 80; end
         default:   begin lim_append = 10; lim_remove = 70; lim_find = 90; end
      endcase
      r = $urandom_range(0, 99);
      if (r < lim_append)
         cmd = CMD_APPEND;
      else if (r < lim_remove)
         cmd = CMD_REMOVE;
      else if (r < lim_find)
         cmd = CMD_FIND;
      else
         cmd = CMD_READ;
      if (cmd == CMD_FIND && recent_total > 0 && $urandom_range(0, 9) < 6) begin
         n = (recent_total < RECENT) ? recent_total : RECENT;
         e = recent_rects[$urandom_range(0, n - 1)];
         px = $signed(e.origin_x) + int'($urandom_range(0, int'(e.width)));
         py = $signed(e.origin_y) + int'($urandom_range(0, int'(e.height)));
      end else begin
         px = rand_coord();
         py = rand_coord();
      end
      add_word(cmd, px, py, rand_size(), rand_size(), pick_index());
   endtask

   // driver
   always @(posedge clock) begin
      bit take_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take_next = !req_valid || !req_stall;
         if (req_valid && !req_stall) begin
            expected_rsp_words.push_back(run_table_command(req_word));
            sent_count++;
         end
         if (take_next) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (command_words.size() > 0) begin
               req_valid <= 1'b1;
               req_word <= command_words.pop_front();
               if (idle_allowed(sent_count) && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 11);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: random bursts plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && checked_count >= 600) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (!idle_allowed(checked_count)) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_words.size() == 0) begin
            $error("response word with none expected: %p", rsp_word);
            error_count++;
         end else begin
            want = expected_rsp_words.pop_front();
            if (rsp_word.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.hit_index !== want.hit_index) begin
               $error("hit_index: expected %0d, got %0d", want.hit_index, rsp_word.hit_index);
               error_count++;
            end
            if (rsp_word.origin_x !== want.origin_x) begin
               $error("origin_x: expected %0d, got %0d", want.origin_x, rsp_word.origin_x);
               error_count++;
            end
            if (rsp_word.origin_y !== want.origin_y) begin
               $error("origin_y: expected %0d, got %0d", want.origin_y, rsp_word.origin_y);
               error_count++;
            end
            checked_count++;
         end
      end
   end

   initial begin
      int i;
      // empty table
      add_word(CMD_FIND, 0, 0, 0, 0, 0);
      add_word(CMD_REMOVE, 0, 0, 0, 0, 0);
      add_word(CMD_READ, 0, 0, 0, 0, 0);
      // extreme, zero-width, zero-height and plain rectangles
      add_word(CMD_APPEND, -32768, -32768, 32767, 32767, 0);
      add_word(CMD_APPEND, 32767, 32767, 32767, 32767, 0);
      add_word(CMD_APPEND, 0, 0, 0, 5, 0);
      add_word(CMD_APPEND, 0, 0, 5, 0, 0);
      add_word(CMD_APPEND, 100, 100, 10, 10, 0);
      // half-open edges and newest-first scan
      add_word(CMD_FIND, 109, 109, 0, 0, 0);
      add_word(CMD_FIND, 110, 105, 0, 0, 0);
      add_word(CMD_FIND, 100, 100, 0, 0, 0);
      add_word(CMD_FIND, 32767, 32767, 0, 0, 0);
      add_word(CMD_FIND, -32768, -32768, 0, 0, 0);
      add_word(CMD_FIND, -2, -2, 0, 0, 0);
      add_word(CMD_FIND, -1, -1, 0, 0, 0);
      add_word(CMD_FIND, 0, 0, 0, 0, 0);
      add_word(CMD_READ, 0, 0, 0, 0, 4);
      add_word(CMD_READ, 0, 0, 0, 0, 5);
      add_word(CMD_READ, 0, 0, 0, 0, 255);
      add_word(CMD_REMOVE, 0, 0, 0, 0, 1);
      add_word(CMD_READ, 0, 0, 0, 0, 1);
      add_word(CMD_REMOVE, 0, 0, 0, 0, 3);
      add_word(CMD_REMOVE, 0, 0, 0, 0, 200);
      add_word(CMD_FIND, 105, 105, 0, 0, 0);
      for (i = 0; i < 1880; i++) begin
         if (i < 450 || (i >= 1250 && i < 1600))
            add_random_word(MIX_GROW);
         else if (i >= 750 && i < 1250)
            add_random_word(MIX_SHRINK);
         else
            add_random_word(MIX_CHURN);
      end
      word_total = command_words.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (!(sent_count == word_total && expected_rsp_words.size() == 0))
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_rsp_words.size() == 0) begin
         $display("** rectangle_hit_test_table_unit: PASSED **");
      end else begin
         $display("** rectangle_hit_test_table_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("** rectangle_hit_test_table_unit: FAILED **");
      $finish;
   end

endmodule
